@@ rtl/trpl_pkg.sv @@
package trpl_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] RegSpanStart = 2'd0;
  localparam logic [1:0] RegSpanEnd   = 2'd1;
  localparam logic [1:0] RegPartCount = 2'd2;
  localparam logic [1:0] RegParCount  = 2'd3;

  // request opcodes
  localparam logic OpBounds = 1'b0;
  localparam logic OpLookup = 1'b1;

  // quotient bits of the pipelined divider
  localparam int DivBits = 16;

  typedef struct packed {
    logic        op;
    logic [15:0] pidx;
    logic [15:0] qidx;
    logic [15:0] qs;
    logic [15:0] qe;
  } req_t;

  // split of one partition size into subranges
  typedef struct packed {
    logic [16:0] c;
    logic [15:0] m;
    logic [16:0] pieces;
    logic [16:0] big;
  } l2_t;

  typedef struct packed {
    logic [15:0] ss;
    logic [15:0] se;
    logic [16:0] c1;
    logic [15:0] m1;
    logic [16:0] pieces1;
    logic [16:0] big1;
    logic        valid1;
    logic        qc_nz;
    l2_t         la;    // partitions of c1 + 1 keys
    l2_t         lb;    // partitions of c1 keys
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        op;
    logic        ok;
    logic        region;
    logic [15:0] pidx;
    logic [15:0] qidx;
    logic [15:0] qs;
    logic [15:0] qe;
    logic [15:0] dividend;
    logic [16:0] divisor;
    logic [15:0] quot;
    logic [16:0] pi;
    logic [17:0] prod;
    logic [17:0] ps;
    l2_t         l2;
    logic [16:0] qi;
    logic [17:0] ss2;
    logic [17:0] len;
  } item_t;

endpackage

@@ rtl/trpl_div.sv @@
module trpl_div import trpl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  item_t in_item,
  output item_t out_item
);

  item_t       st_item [DivBits];
  logic [16:0] st_rem  [DivBits];
  logic [15:0] st_quo  [DivBits];

  item_t       src_item [DivBits];
  logic [16:0] src_rem  [DivBits];
  logic [15:0] src_quo  [DivBits];
  logic [17:0] trial    [DivBits];
  logic [16:0] nxt_rem  [DivBits];
  logic [DivBits-1:0] ge;

  always_comb begin
    src_item[0] = in_item;
    src_rem[0]  = '0;
    src_quo[0]  = '0;
    for (int k = 1; k < DivBits; k++) begin
      src_item[k] = st_item[k-1];
      src_rem[k]  = st_rem[k-1];
      src_quo[k]  = st_quo[k-1];
    end
    // one restoring step per stage, dividend MSB first
    for (int k = 0; k < DivBits; k++) begin
      trial[k]   = {src_rem[k], src_item[k].dividend[DivBits-1-k]};
      ge[k]      = trial[k] >= {1'b0, src_item[k].divisor};
      nxt_rem[k] = ge[k] ? 17'(trial[k] - {1'b0, src_item[k].divisor}) : trial[k][16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DivBits; k++) st_item[k].valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < DivBits; k++) begin
        st_item[k] <= src_item[k];
        st_rem[k]  <= nxt_rem[k];
        st_quo[k]  <= {src_quo[k][14:0], ge[k]};
      end
    end
  end

  always_comb begin
    out_item      = st_item[DivBits-1];
    out_item.quot = st_quo[DivBits-1];
  end

endmodule

@@ rtl/trpl_front.sv @@
module trpl_front import trpl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tuser,
  input  logic        pop,
  output logic        head_valid,
  output req_t        head,
  output cfg_t        cfg
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;
  localparam logic [1:0] StMul  = 2'd3;
  localparam int DivSteps = 17;
  localparam int Depth = 4;

  logic [15:0] span_start, span_end, partition_count, parallel_count;

  logic [1:0]  state;
  logic [1:0]  phase;
  logic [4:0]  cnt;
  logic [16:0] dvd, dvs, quo, rem;
  logic [17:0] trial;
  logic        ge;
  logic [16:0] rem_fin, quo_fin;
  logic [16:0] n1, c1p1;
  logic [16:0] c1, c2a, c2b, pieces1, pieces2a, pieces2b, big1, big2a, big2b;
  logic [15:0] m1, m2a, m2b;
  logic [32:0] big1_full, big2a_full, big2b_full;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_start      <= 16'd0;
      span_end        <= 16'hFFFF;
      partition_count <= 16'd1;
      parallel_count  <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSpanStart: span_start      <= cfg_data;
        RegSpanEnd:   span_end        <= cfg_data;
        RegPartCount: partition_count <= cfg_data;
        RegParCount:  parallel_count  <= cfg_data;
      endcase
    end
  end

  // serial divider rebuilds the derived split constants after any write
  assign n1      = {1'b0, span_end} - {1'b0, span_start} + 17'd1;
  assign c1p1    = c1 + 17'd1;
  assign trial   = {rem, dvd[16]};
  assign ge      = trial >= {1'b0, dvs};
  assign rem_fin = ge ? 17'(trial - {1'b0, dvs}) : trial[16:0];
  assign quo_fin = {quo[15:0], ge};

  assign big1_full  = 33'(m1) * 33'(c1p1);
  assign big2a_full = 33'(m2a) * 33'(c2a + 17'd1);
  assign big2b_full = 33'(m2b) * 33'(c2b + 17'd1);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= StLoad;
      phase <= 2'd0;
    end else begin
      unique case (state)
        StIdle: ;
        StLoad: begin
          rem   <= '0;
          quo   <= '0;
          cnt   <= '0;
          state <= StRun;
          case (phase)
            2'd0: begin
              dvd <= n1;
              dvs <= {1'b0, partition_count};
            end
            2'd1: begin
              dvd <= c1p1;
              dvs <= {1'b0, parallel_count};
            end
            default: begin
              dvd <= c1;
              dvs <= {1'b0, parallel_count};
            end
          endcase
        end
        StRun: begin
          rem <= rem_fin;
          quo <= quo_fin;
          dvd <= {dvd[15:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DivSteps - 1)) begin
            case (phase)
              2'd0: begin
                c1 <= quo_fin;
                m1 <= rem_fin[15:0];
              end
              2'd1: begin
                c2a <= quo_fin;
                m2a <= rem_fin[15:0];
              end
              default: begin
                c2b <= quo_fin;
                m2b <= rem_fin[15:0];
              end
            endcase
            if (phase == 2'd2) begin
              state <= StMul;
            end else begin
              phase <= phase + 2'd1;
              state <= StLoad;
            end
          end
        end
        StMul: begin
          big1     <= big1_full[16:0];
          big2a    <= big2a_full[16:0];
          big2b    <= big2b_full[16:0];
          pieces1  <= ({1'b0, partition_count} < n1) ? {1'b0, partition_count} : n1;
          pieces2a <= ({1'b0, parallel_count} < c1p1) ? {1'b0, parallel_count} : c1p1;
          pieces2b <= ({1'b0, parallel_count} < c1) ? {1'b0, parallel_count} : c1;
          state    <= StIdle;
        end
      endcase
    end
  end

  assign busy = state != StIdle;

  always_comb begin
    cfg.ss        = span_start;
    cfg.se        = span_end;
    cfg.c1        = c1;
    cfg.m1        = m1;
    cfg.pieces1   = pieces1;
    cfg.big1      = big1;
    cfg.valid1    = (partition_count != 16'd0) && (span_start <= span_end);
    cfg.qc_nz     = parallel_count != 16'd0;
    cfg.la.c      = c2a;
    cfg.la.m      = m2a;
    cfg.la.pieces = pieces2a;
    cfg.la.big    = big2a;
    cfg.lb.c      = c2b;
    cfg.lb.m      = m2b;
    cfg.lb.pieces = pieces2b;
    cfg.lb.big    = big2b;
  end

  // request queue toward the back end
  req_t       fifo_mem [Depth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       push, take;

  assign s_tready   = !busy && !cfg_we && (count != 3'(Depth));
  assign push       = s_tvalid && s_tready;
  assign head_valid = count != 3'd0;
  assign take       = pop && head_valid;
  assign head       = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (take) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{op: s_tuser, pidx: s_tdata[15:0], qidx: s_tdata[31:16],
                            qs: s_tdata[47:32], qe: s_tdata[63:48]};
    end
  end

endmodule

@@ rtl/trpl_back.sv @@
module trpl_back import trpl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  req_t        head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic        m_tuser
);

  logic  en;
  item_t s0, r1, d1, s2, r2, s3, r3, s4, r4, d2, s5, r5, s6, r6;

  assign en  = !m_tvalid || m_tready;
  assign pop = en;

  // level one: locate the partition of the query start
  logic [15:0] off1;
  logic        reg1;
  assign off1 = head.qs - cfg.ss;
  assign reg1 = {1'b0, off1} < cfg.big1;

  always_comb begin
    s0          = '0;
    s0.valid    = head_valid;
    s0.op       = head.op;
    s0.pidx     = head.pidx;
    s0.qidx     = head.qidx;
    s0.qs       = head.qs;
    s0.qe       = head.qe;
    s0.region   = reg1;
    s0.dividend = reg1 ? off1 : off1 - cfg.big1[15:0];
    s0.divisor  = reg1 ? cfg.c1 + 17'd1 : cfg.c1;
    if (head.op == OpBounds) begin
      s0.ok = cfg.valid1;
    end else begin
      s0.ok = (head.qs < head.qe) && cfg.valid1 && (head.qs >= cfg.ss) &&
              (head.qs <= cfg.se) && (reg1 || cfg.c1 != 17'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) r1.valid <= 1'b0;
    else if (en) r1 <= s0;
  end

  trpl_div u_div1 (.clk(clk), .rst(rst), .en(en), .in_item(r1), .out_item(d1));

  logic [16:0] pi2;
  logic [33:0] prod1_full;
  assign pi2 = (d1.op == OpBounds) ? {1'b0, d1.pidx} :
               d1.region ? {1'b0, d1.quot} : {1'b0, cfg.m1} + {1'b0, d1.quot};
  assign prod1_full = 34'(pi2) * 34'(cfg.c1);

  always_comb begin
    s2      = d1;
    s2.pi   = pi2;
    s2.ok   = d1.ok && (pi2 < cfg.pieces1);
    s2.prod = prod1_full[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) r2.valid <= 1'b0;
    else if (en) r2 <= s2;
  end

  // partition bounds and choice of its subrange split
  logic        big_part;
  logic [16:0] mn1, sz1;
  logic [17:0] ps3, pe3;
  assign big_part = r2.pi < {1'b0, cfg.m1};
  assign mn1      = big_part ? r2.pi : {1'b0, cfg.m1};
  assign sz1      = big_part ? cfg.c1 + 17'd1 : cfg.c1;
  assign ps3      = {2'b0, cfg.ss} + r2.prod + {1'b0, mn1};
  assign pe3      = ps3 + {1'b0, sz1} - 18'd1;

  always_comb begin
    s3    = r2;
    s3.ps = ps3;
    s3.l2 = big_part ? cfg.la : cfg.lb;
    s3.ok = r2.ok && (r2.op == OpBounds || {2'b0, r2.qe} <= pe3);
  end

  always_ff @(posedge clk) begin
    if (rst) r3.valid <= 1'b0;
    else if (en) r3 <= s3;
  end

  // level two: locate the subrange inside the partition
  logic [15:0] off2;
  logic        reg2;
  assign off2 = r3.qs - r3.ps[15:0];
  assign reg2 = {1'b0, off2} < r3.l2.big;

  always_comb begin
    s4          = r3;
    s4.region   = reg2;
    s4.dividend = reg2 ? off2 : off2 - r3.l2.big[15:0];
    s4.divisor  = reg2 ? r3.l2.c + 17'd1 : r3.l2.c;
    s4.ok       = r3.ok && cfg.qc_nz && (r3.op == OpBounds || reg2 || r3.l2.c != 17'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) r4.valid <= 1'b0;
    else if (en) r4 <= s4;
  end

  trpl_div u_div2 (.clk(clk), .rst(rst), .en(en), .in_item(r4), .out_item(d2));

  logic [16:0] qi5;
  logic [33:0] prod2_full;
  assign qi5 = (d2.op == OpBounds) ? {1'b0, d2.qidx} :
               d2.region ? {1'b0, d2.quot} : {1'b0, d2.l2.m} + {1'b0, d2.quot};
  assign prod2_full = 34'(qi5) * 34'(d2.l2.c);

  always_comb begin
    s5      = d2;
    s5.qi   = qi5;
    s5.ok   = d2.ok && (qi5 < d2.l2.pieces);
    s5.prod = prod2_full[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) r5.valid <= 1'b0;
    else if (en) r5 <= s5;
  end

  logic        big_sub;
  logic [16:0] mn2;
  assign big_sub = r5.qi < {1'b0, r5.l2.m};
  assign mn2     = big_sub ? r5.qi : {1'b0, r5.l2.m};

  always_comb begin
    s6     = r5;
    s6.ss2 = r5.ps + r5.prod + {1'b0, mn2};
    s6.len = {1'b0, r5.l2.c} + {17'b0, big_sub};
  end

  always_ff @(posedge clk) begin
    if (rst) r6.valid <= 1'b0;
    else if (en) r6 <= s6;
  end

  logic [17:0] se7;
  logic        fnd;
  assign se7 = r6.ss2 + r6.len - 18'd1;
  assign fnd = r6.ok && (r6.op == OpBounds ||
                         (r6.ss2 == {2'b0, r6.qs} && se7 == {2'b0, r6.qe}));

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= r6.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= fnd;
      if (!fnd) m_tdata <= '0;
      else if (r6.op == OpBounds) m_tdata <= {32'b0, se7[15:0], r6.ss2[15:0]};
      else m_tdata <= {r6.qi[15:0], r6.pi[15:0], 32'b0};
    end
  end

endmodule

@@ rtl/two_level_range_partition_lookup.sv @@
// Two-level balanced range lookup. One request enters per cycle while
// s_tready is high. The result path holds two 16-stage pipelined
// dividers (partition level, then subrange level), and a 4-entry request
// queue lets input and output stall independently. After
// reset and after every configuration write the split constants are rebuilt
// by a one-bit-per-cycle serial divider (three divides, then a multiply
// step); s_tready stays low meanwhile. Requests: opcode 0 gives
// the bounds of subrange (partition_index, parallel_index); opcode 1 gives
// the indices of the subrange exactly equal to [query_start, query_end].
module two_level_range_partition_lookup import trpl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // partition_index, parallel_index, query_start, query_end
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // range_start, range_end, found_partition, found_parallel
  output logic        m_tuser    // found
);

  cfg_t cfg;
  req_t head;
  logic head_valid, pop;

  trpl_front u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .pop(pop), .head_valid(head_valid), .head(head), .cfg(cfg)
  );

  trpl_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .head_valid(head_valid), .head(head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    else $error("miss result carries nonzero fields");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] <= m_tdata[31:16])
    else $error("subrange start above its end");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("request taken while constants rebuild");

endmodule
